// ===== rtl/core/pds_pkg.sv =====
// percent decoder: shared types, character constants and hex digit helper
package pds_pkg;

    typedef logic [7:0] byte_t;

    // escape progress, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    localparam byte_t      PCT_CHAR     = 8'h25;
    localparam byte_t      SLASH_CHAR   = 8'h2F;
    localparam byte_t      NUL_CHAR     = 8'h00;
    localparam int         NIBBLE_SHIFT = 4;
    localparam logic [4:0] LETTER_BASE  = 5'd10;
    localparam logic [4:0] NO_HEX       = 5'd16;
    localparam int         MAX_RESULTS  = 3;

    // value of a hex digit character, or NO_HEX
    function automatic logic [4:0] hex_nibble(input byte_t ch);
        logic [4:0] val;
        begin
            if (ch >= 8'h30 && ch <= 8'h39)
            begin
                val = {1'b0, 4'(ch - 8'h30)};
            end
            else if (ch >= 8'h41 && ch <= 8'h46)
            begin
                val = {1'b0, 4'(ch - 8'h41)} + LETTER_BASE;
            end
            else if (ch >= 8'h61 && ch <= 8'h66)
            begin
                val = {1'b0, 4'(ch - 8'h61)} + LETTER_BASE;
            end
            else
            begin
                val = NO_HEX;
            end
            return val;
        end
    endfunction

endpackage

// ===== rtl/core/pds_if.sv =====
// percent decoder: raw and decoded character channel interfaces
interface pds_raw_if;
    logic            valid;
    logic            ready;
    pds_pkg::byte_t  in_byte;
    logic            in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pds_dec_if;
    logic            valid;
    logic            ready;
    pds_pkg::byte_t  out_byte;
    logic            out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/percent_decoder_stream.sv =====
// percent decoder: url escape decoding of a character stream
//
//  channel   role   payload              meaning
//  raw       sink   in_byte, in_last     raw name characters, last marks end of name
//  decoded   source out_byte, out_last   decoded characters, last on final one of name
//
//  a request is decoded in the cycle it is taken; its 0..3 characters sit in a
//  three-entry result buffer and leave one per cycle, so one character per cycle
//  is sustained and the characters of a request leave in order
//  the raw side is ready when the buffer is empty or its last entry is leaving
//  rst_n clears escape state and empties the buffer; held characters are dropped
//  stalls on the decoded side hold the buffer and back-pressure the raw side
module percent_decoder_stream (
    input  logic         clk,
    input  logic         rst_n,
    pds_raw_if.sink      raw,
    pds_dec_if.source    decoded
);

    pds_pkg::phase_t phase_reg, phase_next;
    pds_pkg::byte_t  held_reg, held_next;

    pds_pkg::byte_t  buf_reg [pds_pkg::MAX_RESULTS];
    logic [1:0]      cnt_reg;
    logic            last_reg;

    pds_pkg::byte_t  res [pds_pkg::MAX_RESULTS];
    logic [1:0]      res_cnt;

    logic            take;
    logic            pop;

    assign decoded.valid    = (cnt_reg != 2'd0);
    assign decoded.out_byte = buf_reg[0];
    assign decoded.out_last = last_reg && (cnt_reg == 2'd1);
    assign raw.ready        = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && decoded.ready);

    assign take = raw.valid && raw.ready;
    assign pop  = decoded.valid && decoded.ready;

    always_comb
    begin
        logic [4:0]     lo;
        logic [4:0]     hi;
        pds_pkg::byte_t val;
        logic           rescan;

        lo         = pds_pkg::hex_nibble(raw.in_byte);
        hi         = pds_pkg::hex_nibble(held_reg);
        val        = {hi[3:0], lo[3:0]};
        rescan     = 1'b0;
        res        = '{default: '0};
        res_cnt    = 2'd0;
        phase_next = phase_reg;
        held_next  = held_reg;

        unique case (phase_reg)
            pds_pkg::PH_PCT:
            begin
                if (lo != pds_pkg::NO_HEX)
                begin
                    held_next  = raw.in_byte;
                    phase_next = pds_pkg::PH_DIGIT;
                end
                else
                begin
                    res[res_cnt] = pds_pkg::PCT_CHAR;
                    res_cnt      = res_cnt + 2'd1;
                    rescan       = 1'b1;
                end
            end
            pds_pkg::PH_DIGIT:
            begin
                if (lo != pds_pkg::NO_HEX)
                begin
                    if (val != pds_pkg::NUL_CHAR && val != pds_pkg::SLASH_CHAR)
                    begin
                        res[0]  = val;
                        res_cnt = 2'd1;
                    end
                    else
                    begin
                        res[0]  = pds_pkg::PCT_CHAR;
                        res[1]  = held_reg;
                        res[2]  = raw.in_byte;
                        res_cnt = 2'd3;
                    end
                    phase_next = pds_pkg::PH_IDLE;
                end
                else
                begin
                    res[0]  = pds_pkg::PCT_CHAR;
                    res[1]  = held_reg;
                    res_cnt = 2'd2;
                    rescan  = 1'b1;
                end
            end
            default:
            begin
                rescan = 1'b1;
            end
        endcase

        if (rescan)
        begin
            if (raw.in_byte == pds_pkg::PCT_CHAR)
            begin
                phase_next = pds_pkg::PH_PCT;
            end
            else
            begin
                res[res_cnt] = raw.in_byte;
                res_cnt      = res_cnt + 2'd1;
                phase_next   = pds_pkg::PH_IDLE;
            end
        end

        // end of name flushes whatever is still held
        if (raw.in_last)
        begin
            if (phase_next == pds_pkg::PH_PCT)
            begin
                res[res_cnt] = pds_pkg::PCT_CHAR;
                res_cnt      = res_cnt + 2'd1;
            end
            else if (phase_next == pds_pkg::PH_DIGIT)
            begin
                res[0]  = pds_pkg::PCT_CHAR;
                res[1]  = held_next;
                res[2]  = raw.in_byte;
                res_cnt = 2'd3;
            end
            phase_next = pds_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pds_pkg::PH_IDLE;
            held_reg  <= '0;
            cnt_reg   <= 2'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                cnt_reg   <= res_cnt;
                last_reg  <= raw.in_last;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // result buffer drains from entry 0
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg <= res;
        end
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("escape phase not one-hot");

    a_last_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        take && raw.in_last |=> phase_reg == pds_pkg::PH_IDLE)
        else $error("escape still pending after end of name");

    a_last_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
        take && raw.in_last |=> cnt_reg != 2'd0 && last_reg)
        else $error("end of name produced no final character");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        raw.ready |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
        else $error("request taken while buffer still holds characters");

endmodule

// ===== tb/pds_decode_checker.sv =====
// percent decoder testbench: channel monitor, decode predictor and result comparison
`timescale 1ns / 100ps

module pds_decode_checker
(
    input  logic clk,
    input  logic rst_n,
    pds_raw_if   raw,
    pds_dec_if   decoded,
    output int   fail_count,
    output int   chars_pending,
    output int   chars_checked
);

    typedef struct packed {
        pds_pkg::byte_t chr;
        logic           ends_name;
    } dec_char_t;

    // predictor's own copy of the escape state
    pds_pkg::phase_t esc_phase = pds_pkg::PH_IDLE;
    pds_pkg::byte_t  held_char = '0;

    pds_pkg::byte_t  step_chars[$];
    dec_char_t       decoded_due[$];
    dec_char_t       want;
    int              mismatches = 0;
    int              checked = 0;

    function automatic logic [4:0] nibble_of(input pds_pkg::byte_t c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "A" && c <= "F")
            return 5'(c - "A") + pds_pkg::LETTER_BASE;
        if (c >= "a" && c <= "f")
            return 5'(c - "a") + pds_pkg::LETTER_BASE;
        return pds_pkg::NO_HEX;
    endfunction

    // character seen with no escape open
    function automatic void scan_plain(input pds_pkg::byte_t c);
        if (c == pds_pkg::PCT_CHAR)
        begin
            esc_phase = pds_pkg::PH_PCT;
        end
        else
        begin
            step_chars.push_back(c);
            esc_phase = pds_pkg::PH_IDLE;
        end
    endfunction

    task automatic decode_raw_char(input pds_pkg::byte_t c, input logic is_last);
        logic [4:0]     lo;
        logic [4:0]     hi;
        pds_pkg::byte_t val;
        dec_char_t      item;
        step_chars.delete();
        lo = nibble_of(c);
        case (esc_phase)
            pds_pkg::PH_PCT:
            begin
                if (lo != pds_pkg::NO_HEX)
                begin
                    held_char = c;
                    esc_phase = pds_pkg::PH_DIGIT;
                end
                else
                begin
                    step_chars.push_back(pds_pkg::PCT_CHAR);
                    scan_plain(c);
                end
            end
            pds_pkg::PH_DIGIT:
            begin
                hi = nibble_of(held_char);
                if (lo != pds_pkg::NO_HEX)
                begin
                    val = (8'(hi[3:0]) << pds_pkg::NIBBLE_SHIFT) | 8'(lo[3:0]);
                    // nul and slash are never produced, the escape stays as written
                    if (val != pds_pkg::NUL_CHAR && val != pds_pkg::SLASH_CHAR)
                    begin
                        step_chars.push_back(val);
                    end
                    else
                    begin
                        step_chars.push_back(pds_pkg::PCT_CHAR);
                        step_chars.push_back(held_char);
                        step_chars.push_back(c);
                    end
                    esc_phase = pds_pkg::PH_IDLE;
                end
                else
                begin
                    step_chars.push_back(pds_pkg::PCT_CHAR);
                    step_chars.push_back(held_char);
                    scan_plain(c);
                end
            end
            default:
            begin
                scan_plain(c);
            end
        endcase
        // end of name flushes whatever is held; the closing char is repeated
        if (is_last)
        begin
            if (esc_phase == pds_pkg::PH_PCT)
            begin
                step_chars.push_back(pds_pkg::PCT_CHAR);
            end
            else if (esc_phase == pds_pkg::PH_DIGIT)
            begin
                step_chars.push_back(pds_pkg::PCT_CHAR);
                step_chars.push_back(held_char);
                step_chars.push_back(c);
            end
            esc_phase = pds_pkg::PH_IDLE;
        end
        foreach (step_chars[i])
        begin
            item.chr       = step_chars[i];
            item.ends_name = is_last && (i == step_chars.size() - 1);
            decoded_due.push_back(item);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_phase = pds_pkg::PH_IDLE;
            held_char = '0;
            decoded_due.delete();
            fail_count    <= 0;
            chars_pending <= 0;
            chars_checked <= 0;
        end
        else
        begin
            if (raw.valid && raw.ready)
                decode_raw_char(raw.in_byte, raw.in_last);
            if (decoded.valid && decoded.ready)
            begin
                if (decoded_due.size() == 0)
                begin
                    $error("out_byte: expected nothing, got %02h", decoded.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = decoded_due.pop_front();
                    checked++;
                    if (decoded.out_byte !== want.chr)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.chr,
                               decoded.out_byte);
                        mismatches++;
                    end
                    if (decoded.out_last !== want.ends_name)
                    begin
                        $error("out_last: expected %0b, got %0b", want.ends_name,
                               decoded.out_last);
                        mismatches++;
                    end
                end
            end
            fail_count    <= mismatches;
            chars_pending <= decoded_due.size();
            chars_checked <= checked;
        end
    end

endmodule

// ===== tb/percent_decoder_stream_tb.sv =====
// percent decoder testbench: clock, reset, name stimulus, back-pressure and verdict
`timescale 1ns / 100ps

module percent_decoder_stream_tb;

    localparam int RANDOM_ITEMS = 230;
    localparam int MAX_GAP      = 11;
    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 200000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    int             cycle_count = 0;
    int             fail_count;
    int             chars_pending;
    int             chars_checked;
    int             sent_count = 0;
    int             names_sent = 0;
    int             directed_count;
    bit             steady = 1'b0;
    bit             long_hold_req = 1'b0;
    bit             hold_done = 1'b0;
    bit             pause_done = 1'b0;
    pds_pkg::byte_t name_buf[$];

    pds_raw_if raw_ch();
    pds_dec_if dec_ch();

    percent_decoder_stream u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_ch),
        .decoded (dec_ch)
    );

    pds_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .raw           (raw_ch),
        .decoded       (dec_ch),
        .fail_count    (fail_count),
        .chars_pending (chars_pending),
        .chars_checked (chars_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("percent_decoder_stream_tb: errors");
            $finish;
        end
    end

    function automatic bit is_hex(input pds_pkg::byte_t c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // digit character for a nibble, letters in either case
    function automatic pds_pkg::byte_t hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return pds_pkg::byte_t'("0") + pds_pkg::byte_t'(n);
        if ($urandom_range(0, 1) == 1)
            return pds_pkg::byte_t'("A") + pds_pkg::byte_t'(n - 4'd10);
        return pds_pkg::byte_t'("a") + pds_pkg::byte_t'(n - 4'd10);
    endfunction

    function automatic pds_pkg::byte_t non_hex_char();
        pds_pkg::byte_t c;
        do
            c = pds_pkg::byte_t'($urandom_range(0, 255));
        while (is_hex(c));
        return c;
    endfunction

    task automatic send_request(input pds_pkg::byte_t c, input logic is_last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            raw_ch.valid   <= 1'b0;
            raw_ch.in_byte <= pds_pkg::byte_t'($urandom_range(0, 255));
            raw_ch.in_last <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        raw_ch.valid   <= 1'b1;
        raw_ch.in_byte <= c;
        raw_ch.in_last <= is_last;
        do
            @(posedge clk);
        while (!raw_ch.ready);
        sent_count++;
        if (is_last)
            names_sent++;
    endtask

    task automatic send_text(input string s, input logic ends_name);
        for (int i = 0; i < s.len(); i++)
            send_request(pds_pkg::byte_t'(s[i]), ends_name && (i == s.len() - 1));
    endtask

    // sender stops until every decoded char has come out
    task automatic wait_drained();
        raw_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (chars_pending != 0);
    endtask

    task automatic build_name();
        int             tokens;
        int             kind;
        pds_pkg::byte_t v;
        name_buf.delete();
        tokens = $urandom_range(1, 8);
        repeat (tokens)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                v = pds_pkg::byte_t'($urandom_range(0, 255));
                if ($urandom_range(0, 6) == 0)
                    v = ($urandom_range(0, 1) == 1) ? pds_pkg::SLASH_CHAR : pds_pkg::NUL_CHAR;
                name_buf.push_back(pds_pkg::PCT_CHAR);
                name_buf.push_back(hex_char(v[7:4]));
                name_buf.push_back(hex_char(v[3:0]));
            end
            else if (kind < 65)
            begin
                name_buf.push_back(pds_pkg::byte_t'($urandom_range(0, 255)));
            end
            else if (kind < 80)
            begin
                name_buf.push_back(pds_pkg::PCT_CHAR);
                name_buf.push_back(non_hex_char());
            end
            else if (kind < 92)
            begin
                name_buf.push_back(pds_pkg::PCT_CHAR);
                name_buf.push_back(hex_char(4'($urandom_range(0, 15))));
                name_buf.push_back(non_hex_char());
            end
            else
            begin
                name_buf.push_back(pds_pkg::PCT_CHAR);
            end
        end
        // name cut off inside an escape
        if ($urandom_range(0, 5) == 0)
        begin
            name_buf.push_back(pds_pkg::PCT_CHAR);
            if ($urandom_range(0, 1) == 1)
                name_buf.push_back(hex_char(4'($urandom_range(0, 15))));
        end
    endtask

    // receiver: random stalls, steady stretches and one long hold-off
    initial
    begin
        int stall;
        dec_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                stall = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else
            begin
                stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                dec_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dec_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!dec_ch.valid);
        end
    end

    initial
    begin
        raw_ch.valid   <= 1'b0;
        raw_ch.in_byte <= '0;
        raw_ch.in_last <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // good escape, forbidden values, bad second and third chars, flushes
        send_text("%41", 1'b1);
        send_text("%2f", 1'b0);
        send_text("%00", 1'b0);
        send_text("%g", 1'b0);
        send_text("%4x", 1'b0);
        send_text("%%6a", 1'b1);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_text("%", 1'b1);
        send_text("%F", 1'b1);
        directed_count = sent_count;
        wait_drained();

        while (sent_count < directed_count + RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (!hold_done && sent_count > directed_count + RANDOM_ITEMS / 3)
            begin
                // keep offering requests while the output side is held off
                steady = 1'b1;
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent_count > directed_count + 2 * RANDOM_ITEMS / 3)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            build_name();
            foreach (name_buf[i])
                send_request(name_buf[i], i == name_buf.size() - 1);
        end
        steady = 1'b0;

        raw_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (chars_pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d raw requests over %0d names, %0d decoded chars compared",
                 sent_count, names_sent, chars_checked);
        $display("including one long output hold-off and one input pause to empty");
        if (fail_count == 0)
            $display("percent_decoder_stream_tb: clean");
        else
            $display("percent_decoder_stream_tb: errors");
        $finish;
    end

endmodule

// ===== percent_decoder_stream.f =====
rtl/core/pds_pkg.sv
rtl/core/pds_if.sv
rtl/core/percent_decoder_stream.sv
tb/pds_decode_checker.sv
tb/percent_decoder_stream_tb.sv
